[rtl/core/whp_pkg.sv]
`timescale 1ns / 1ps

package whp_pkg;

	// Result kinds, as carried on the output tuser.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_RIFF   = 3'd1;
	localparam logic [2:0] ERR_NO_WAVE   = 3'd2;
	localparam logic [2:0] ERR_NO_FMT    = 3'd3;
	localparam logic [2:0] ERR_FMT_SMALL = 3'd4;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd5;
	localparam logic [2:0] ERR_NO_DATA   = 3'd6;
	localparam logic [2:0] ERR_TRUNC     = 3'd7;

	// Sample format codes.
	localparam logic [2:0] FMT_MONO8    = 3'd0;
	localparam logic [2:0] FMT_MONO16   = 3'd1;
	localparam logic [2:0] FMT_STEREO8  = 3'd2;
	localparam logic [2:0] FMT_STEREO16 = 3'd3;
	localparam logic [2:0] FMT_QUAD16   = 3'd4;
	localparam logic [2:0] FMT_CH51     = 3'd5;
	localparam logic [2:0] FMT_CH61     = 3'd6;
	localparam logic [2:0] FMT_CH71     = 3'd7;

	// Queue between the parser and the result stage.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Output tdata width: 146 bits of fields padded to whole bytes.
	localparam int M_TDATA_W = 152;

	// Event handed from the parser to the result stage.
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  err;
		logic [7:0]  pbyte;
		logic        last;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] size;
	} event_t;

	// Finished result item.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  pbyte;
		logic        last;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [31:0] size;
		logic [34:0] bufb;
		logic [2:0]  fmt;
		logic        guess;
		logic [2:0]  err;
	} result_t;

endpackage

[rtl/core/whp_front.sv]
`timescale 1ns / 1ps

// Byte parser: walks the RIFF/WAVE header one byte per transfer and posts
// header, payload and error events to the queue.
module whp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              start_of_file,
	input  logic              end_of_file,
	output logic              ev_push,
	output whp_pkg::event_t   ev,
	input  logic              ev_space
);

	localparam logic [4:0] PH_RIFF    = 5'd0;
	localparam logic [4:0] PH_RSIZE   = 5'd1;
	localparam logic [4:0] PH_WAVE    = 5'd2;
	localparam logic [4:0] PH_FMT     = 5'd3;
	localparam logic [4:0] PH_FSIZE   = 5'd4;
	localparam logic [4:0] PH_AFMT    = 5'd5;
	localparam logic [4:0] PH_CHAN    = 5'd6;
	localparam logic [4:0] PH_RATE    = 5'd7;
	localparam logic [4:0] PH_SKIP6   = 5'd8;
	localparam logic [4:0] PH_BITS    = 5'd9;
	localparam logic [4:0] PH_FEXTRA  = 5'd10;
	localparam logic [4:0] PH_TAG1    = 5'd11;
	localparam logic [4:0] PH_FACT    = 5'd12;
	localparam logic [4:0] PH_TAG2    = 5'd13;
	localparam logic [4:0] PH_DSIZE   = 5'd14;
	localparam logic [4:0] PH_PAYLOAD = 5'd15;
	localparam logic [4:0] PH_DONE    = 5'd16;
	localparam logic [4:0] PH_ERROR   = 5'd17;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] FMT_MIN  = 32'd16;

	// Number of bytes in the field read in each header phase.
	function automatic logic [3:0] field_len(input logic [4:0] ph);
		logic [3:0] len;
		case (ph)
			PH_AFMT, PH_CHAN, PH_BITS: len = 4'd2;
			PH_SKIP6:                  len = 4'd6;
			PH_FEXTRA:                 len = 4'd1;
			PH_FACT:                   len = 4'd8;
			default:                   len = 4'd4;
		endcase
		return len;
	endfunction

	logic [4:0]  phase_q;
	logic [3:0]  bif_q;
	logic [31:0] shift_q;
	logic [31:0] extra_q;
	logic [15:0] chan_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic [31:0] left_q;

	logic [4:0]  eff_phase, nxt_phase;
	logic [3:0]  eff_bif, nxt_bif, bif_inc;
	logic [31:0] eff_shift, nxt_shift, sh_new;
	logic [31:0] eff_extra, nxt_extra;
	logic [15:0] eff_chan, nxt_chan;
	logic [31:0] eff_rate, nxt_rate;
	logic [15:0] eff_bits, nxt_bits;
	logic [31:0] eff_left, nxt_left, left_dec, extra_dec;
	logic        accept;
	logic        push;
	whp_pkg::event_t ev_d;

	assign in_ready = ev_space;
	assign accept   = in_valid & in_ready;
	assign ev_push  = accept & push;
	assign ev       = ev_d;

	// Next-state logic for one accepted byte.
	always_comb begin
		// A start-of-file marker clears the state before the byte is used.
		eff_phase = start_of_file ? PH_RIFF : phase_q;
		eff_bif   = start_of_file ? 4'd0 : bif_q;
		eff_shift = start_of_file ? 32'd0 : shift_q;
		eff_extra = start_of_file ? 32'd0 : extra_q;
		eff_chan  = start_of_file ? 16'd0 : chan_q;
		eff_rate  = start_of_file ? 32'd0 : rate_q;
		eff_bits  = start_of_file ? 16'd0 : bits_q;
		eff_left  = start_of_file ? 32'd0 : left_q;

		nxt_phase = eff_phase;
		nxt_bif   = eff_bif;
		nxt_shift = eff_shift;
		nxt_extra = eff_extra;
		nxt_chan  = eff_chan;
		nxt_rate  = eff_rate;
		nxt_bits  = eff_bits;
		nxt_left  = eff_left;

		sh_new    = {in_byte, eff_shift[31:8]};
		bif_inc   = eff_bif + 4'd1;
		left_dec  = eff_left - 32'd1;
		extra_dec = eff_extra - 32'd1;
		push      = 1'b0;
		ev_d      = '0;

		if (eff_phase == PH_PAYLOAD) begin
			// Pass a payload byte through and count it off.
			nxt_left      = left_dec;
			push          = 1'b1;
			ev_d.kind     = whp_pkg::KIND_PAYLOAD;
			ev_d.pbyte    = in_byte;
			ev_d.last     = (left_dec == 32'd0) | end_of_file;
			if (left_dec == 32'd0) begin
				nxt_phase = PH_DONE;
			end
		end else if (eff_phase == PH_FEXTRA) begin
			// Skip fmt bytes beyond the sixteen that are decoded.
			nxt_extra = extra_dec;
			if (extra_dec == 32'd0) begin
				nxt_phase = PH_TAG1;
			end
		end else if (eff_phase <= PH_DSIZE) begin
			// Shift the byte in; judge the field once it is complete.
			nxt_shift = sh_new;
			if (bif_inc >= field_len(eff_phase)) begin
				nxt_bif = 4'd0;
				case (eff_phase)
					PH_RIFF: begin
						if (sh_new != TAG_RIFF) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NO_RIFF;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_phase = PH_RSIZE;
						end
					end
					PH_RSIZE: begin
						nxt_phase = PH_WAVE;
					end
					PH_WAVE: begin
						if (sh_new != TAG_WAVE) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NO_WAVE;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_phase = PH_FMT;
						end
					end
					PH_FMT: begin
						if (sh_new != TAG_FMT) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NO_FMT;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_phase = PH_FSIZE;
						end
					end
					PH_FSIZE: begin
						if (sh_new < FMT_MIN) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_FMT_SMALL;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_extra = sh_new - FMT_MIN;
							nxt_phase = PH_AFMT;
						end
					end
					PH_AFMT: begin
						if (sh_new[31:16] != 16'd1) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NOT_PCM;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_phase = PH_CHAN;
						end
					end
					PH_CHAN: begin
						nxt_chan  = sh_new[31:16];
						nxt_phase = PH_RATE;
					end
					PH_RATE: begin
						nxt_rate  = sh_new;
						nxt_phase = PH_SKIP6;
					end
					PH_SKIP6: begin
						nxt_phase = PH_BITS;
					end
					PH_BITS: begin
						nxt_bits  = sh_new[31:16];
						nxt_phase = (eff_extra != 32'd0) ? PH_FEXTRA : PH_TAG1;
					end
					PH_TAG1: begin
						if (sh_new == TAG_DATA) begin
							nxt_phase = PH_DSIZE;
						end else if (sh_new == TAG_FACT) begin
							nxt_phase = PH_FACT;
						end else begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NO_DATA;
							nxt_phase = PH_ERROR;
						end
					end
					PH_FACT: begin
						nxt_phase = PH_TAG2;
					end
					PH_TAG2: begin
						if (sh_new != TAG_DATA) begin
							push = 1'b1;
							ev_d.kind = whp_pkg::KIND_ERROR;
							ev_d.err  = whp_pkg::ERR_NO_DATA;
							nxt_phase = PH_ERROR;
						end else begin
							nxt_phase = PH_DSIZE;
						end
					end
					PH_DSIZE: begin
						// Header complete: post it and start the payload.
						push      = 1'b1;
						ev_d.kind = whp_pkg::KIND_HEADER;
						ev_d.chan = eff_chan;
						ev_d.rate = eff_rate;
						ev_d.bits = eff_bits;
						ev_d.size = sh_new;
						nxt_left  = sh_new;
						nxt_phase = (sh_new != 32'd0) ? PH_PAYLOAD : PH_DONE;
					end
					default: begin
						nxt_phase = eff_phase;
					end
				endcase
			end else begin
				nxt_bif = bif_inc;
			end
		end

		// End of file: flag a short header, then return to the reset state.
		if (end_of_file) begin
			if (!push && (nxt_phase < PH_PAYLOAD)) begin
				push      = 1'b1;
				ev_d      = '0;
				ev_d.kind = whp_pkg::KIND_ERROR;
				ev_d.err  = whp_pkg::ERR_TRUNC;
			end
			nxt_phase = PH_RIFF;
			nxt_bif   = 4'd0;
			nxt_shift = 32'd0;
			nxt_extra = 32'd0;
			nxt_chan  = 16'd0;
			nxt_rate  = 32'd0;
			nxt_bits  = 16'd0;
			nxt_left  = 32'd0;
		end
	end

	// Parser state registers, updated on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			bif_q   <= 4'd0;
			shift_q <= 32'd0;
			extra_q <= 32'd0;
			chan_q  <= 16'd0;
			rate_q  <= 32'd0;
			bits_q  <= 16'd0;
			left_q  <= 32'd0;
		end else if (accept) begin
			phase_q <= nxt_phase;
			bif_q   <= nxt_bif;
			shift_q <= nxt_shift;
			extra_q <= nxt_extra;
			chan_q  <= nxt_chan;
			rate_q  <= nxt_rate;
			bits_q  <= nxt_bits;
			left_q  <= nxt_left;
		end
	end

endmodule

[rtl/core/whp_fifo.sv]
`timescale 1ns / 1ps

// Short event queue between the parser and the result stage.
module whp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  whp_pkg::event_t wr_data,
	output logic            wr_space,
	input  logic            rd_en,
	output whp_pkg::event_t rd_data,
	output logic            rd_valid
);

	whp_pkg::event_t entry_q [whp_pkg::QDEPTH];
	logic [whp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [whp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [whp_pkg::QCNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_space = (count_q != whp_pkg::QCNT_W'(whp_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en & wr_space;
	assign do_rd    = rd_en & rd_valid;
	assign rd_data  = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == whp_pkg::QPTR_W'(whp_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == whp_pkg::QPTR_W'(whp_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/whp_back.sv]
`timescale 1ns / 1ps

// Result stage: derives the sample format and buffer size for headers and
// holds each finished result in the output register.
module whp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  whp_pkg::event_t   ev,
	input  logic              ev_valid,
	output logic              ev_pop,
	output whp_pkg::result_t  res,
	output logic              res_valid,
	input  logic              res_ready
);

	whp_pkg::result_t out_q;
	logic             out_valid_q;
	whp_pkg::result_t res_d;
	logic [34:0]      r4;
	logic [2:0]       fmt;
	logic             guess;
	logic [34:0]      bufb;

	assign ev_pop    = ev_valid & (~out_valid_q | res_ready);
	assign res       = out_q;
	assign res_valid = out_valid_q;

	// Rate rounded down to a multiple of four; the 16-bit stereo buffer and every buffer for four
	// or more channels is a small multiple of it.
	assign r4 = {3'b000, ev.rate[31:2], 2'b00};

	// Format and buffer size from the channel count and sample size; through 5.1 the buffer holds a quarter second.
	always_comb begin
		guess = 1'b0;
		case (ev.chan)
			16'd1: begin
				if (ev.bits == 16'd8) begin
					fmt  = whp_pkg::FMT_MONO8;
					bufb = {5'd0, ev.rate[31:2]};
				end else begin
					fmt  = whp_pkg::FMT_MONO16;
					bufb = {4'd0, ev.rate[31:2], 1'b0};
				end
			end
			16'd2: begin
				if (ev.bits == 16'd8) begin
					fmt  = whp_pkg::FMT_STEREO8;
					bufb = {4'd0, ev.rate[31:2], 1'b0};
				end else begin
					fmt  = whp_pkg::FMT_STEREO16;
					bufb = r4;
				end
			end
			16'd4: begin
				fmt  = whp_pkg::FMT_QUAD16;
				bufb = {r4[33:0], 1'b0};
			end
			16'd6: begin
				fmt  = whp_pkg::FMT_CH51;
				bufb = r4 + {r4[33:0], 1'b0};
			end
			16'd7: begin
				fmt  = whp_pkg::FMT_CH61;
				bufb = {r4[32:0], 2'b00};
			end
			16'd8: begin
				fmt  = whp_pkg::FMT_CH71;
				bufb = r4 + {r4[32:0], 2'b00};
			end
			default: begin
				fmt   = whp_pkg::FMT_MONO16;
				guess = 1'b1;
				bufb  = {4'd0, ev.rate[31:2], 1'b0};
			end
		endcase
	end

	// Assemble the result; fields a kind does not use stay zero.
	always_comb begin
		res_d       = '0;
		res_d.kind  = ev.kind;
		res_d.pbyte = ev.pbyte;
		res_d.last  = ev.last;
		res_d.chan  = ev.chan;
		res_d.rate  = ev.rate;
		res_d.bits  = ev.bits;
		res_d.size  = ev.size;
		res_d.err   = ev.err;
		if (ev.kind == whp_pkg::KIND_HEADER) begin
			res_d.bufb  = bufb;
			res_d.fmt   = fmt;
			res_d.guess = guess;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (ev_pop) begin
			out_q <= res_d;
		end
	end

	// Output valid: set on a pop, cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ev_pop) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/wav_header_parser_top.sv]
`timescale 1ns / 1ps
// Each result is registered in the event queue and then in the output register.
// Throughput: one file byte per cycle while the event queue has space; the two-entry
// event queue and the output register let input and output stall independently.
// Reset: arst_n, asynchronous and active low, puts the parser back to waiting
// for the RIFF tag and empties the queue and the output register.
module wav_header_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] in_byte
	input  logic [0:0]                      s_axis_tuser,  // [0] start_of_file
	input  logic                            s_axis_tlast,  // end_of_file
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [7:0] payload_byte, [23:8] channel_count, [55:24] sample_rate,
	// [71:56] bits_per_sample, [103:72] declared_data_size,
	// [138:104] buffer_bytes, [141:139] sample_format, [142] format_guessed,
	// [145:143] error_code, [151:146] zero
	output logic [whp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,  // [1:0] result_kind
	output logic                            m_axis_tlast   // last_payload
);

	whp_pkg::event_t  fr_ev;
	logic             fr_push;
	logic             q_space;
	whp_pkg::event_t  q_ev;
	logic             q_valid;
	logic             q_pop;
	whp_pkg::result_t res;

	// Parser front end.
	whp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_byte       (s_axis_tdata),
		.start_of_file (s_axis_tuser[0]),
		.end_of_file   (s_axis_tlast),
		.ev_push       (fr_push),
		.ev            (fr_ev),
		.ev_space      (q_space)
	);

	// Event queue.
	whp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fr_push),
		.wr_data  (fr_ev),
		.wr_space (q_space),
		.rd_en    (q_pop),
		.rd_data  (q_ev),
		.rd_valid (q_valid)
	);

	// Result stage.
	whp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev        (q_ev),
		.ev_valid  (q_valid),
		.ev_pop    (q_pop),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	// Output packing, first field in the lowest bits.
	assign m_axis_tdata = {6'd0, res.err, res.guess, res.fmt, res.bufb, res.size,
		res.bits, res.rate, res.chan, res.pbyte};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

[rtl/core/whp_checker.sv]
`timescale 1ns / 1ps

// Port-level checks on the parser's output stream.
module whp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [whp_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);

	// A stalled result stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output result changed while stalled");

	// Only payload bytes may close a run.
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == whp_pkg::KIND_PAYLOAD)
		else $error("tlast on a result that is not payload");

	// An error result always carries a non-zero code, other results none.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			((m_axis_tuser == whp_pkg::KIND_ERROR) ==
				(m_axis_tdata[145:143] != whp_pkg::ERR_NONE)))
		else $error("error code does not match result kind");

	// A header for eight channels is reported as 7.1 and not guessed.
	a_ch71: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == whp_pkg::KIND_HEADER &&
			m_axis_tdata[23:8] == 16'd8 |->
			m_axis_tdata[141:139] == whp_pkg::FMT_CH71 && !m_axis_tdata[142])
		else $error("eight-channel header given the wrong format");

endmodule

bind wav_header_parser_top whp_checker u_whp_checker (.*);
